### rtl/lms_pkg.sv
// ----------------------------------------------------------------------------
// lms_pkg
// Shared types, command codes and pin tables for the LED matrix scanner.
// ----------------------------------------------------------------------------
package lms_pkg;

  localparam int unsigned ROWS      = 8;
  localparam int unsigned COLS      = 8;
  localparam int unsigned DOTS      = ROWS * COLS;
  localparam int unsigned ROW_W     = $clog2(ROWS);
  localparam int unsigned COL_W     = $clog2(COLS);
  localparam int unsigned POS_W     = $clog2(DOTS);
  localparam int unsigned WORD_W    = 16;
  localparam int unsigned PIN_W     = $clog2(WORD_W);

  localparam logic [1:0] CMD_SHIFT   = 2'd0;
  localparam logic [1:0] CMD_CLEAR   = 2'd1;
  localparam logic [1:0] CMD_REFRESH = 2'd2;

  // All row drives low, all column drives high.
  localparam logic [WORD_W-1:0] OFF_WORD = 16'h6B2C;

  localparam logic [PIN_W-1:0] ROW_PIN [ROWS] = '{
    4'd15, 4'd10, 4'd7, 4'd12, 4'd0, 4'd6, 4'd1, 4'd4
  };
  localparam logic [PIN_W-1:0] COL_PIN [COLS] = '{
    4'd11, 4'd2, 4'd3, 4'd14, 4'd5, 4'd13, 4'd9, 4'd8
  };

  typedef struct packed {
    logic shift;
    logic clear;
    logic load_scan;
    logic step;
    logic emit_dot;
    logic emit_off;
  } lms_cmd_t;

  typedef struct packed {
    logic frame_empty;
    logic cur_lit;
    logic more_lit;
    logic slot_free;
  } lms_sts_t;

  function automatic logic [WORD_W-1:0] dot_word(input logic [ROW_W-1:0] row,
                                                 input logic [COL_W-1:0] col);
    logic [WORD_W-1:0] w;
    w = OFF_WORD;
    w[ROW_PIN[row]] = 1'b1;
    w[COL_PIN[col]] = 1'b0;
    return w;
  endfunction

endpackage

### rtl/lms_if.sv
// ----------------------------------------------------------------------------
// lms_if
// Valid/ready channels for commands and scan words.
// ----------------------------------------------------------------------------
interface lms_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] column_bits;

  modport source (output valid, output command, output column_bits, input ready);
  modport sink   (input valid, input command, input column_bits, output ready);
endinterface

interface lms_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] serial_word;
  logic [2:0]  dot_row;
  logic [2:0]  dot_column;
  logic        blank;
  logic        last;

  modport source (output valid, output serial_word, output dot_row, output dot_column,
                  output blank, output last, input ready);
  modport sink   (input valid, input serial_word, input dot_row, input dot_column,
                  input blank, input last, output ready);
endinterface

### rtl/led_matrix_scroll_dot_scanner_core.sv
// ----------------------------------------------------------------------------
// led_matrix_scroll_dot_scanner_core
// Scrolling 8x8 dot frame with a refresh scanner that emits one 16-bit
// drive word per lit dot.
// ----------------------------------------------------------------------------
// Channel  Dir  Fields                                       Handshake
// in_ch    in   command[1:0], column_bits[7:0]               valid/ready
// out_ch   out  serial_word[15:0], dot_row[2:0],             valid/ready
//               dot_column[2:0], blank, last
//
// A shift gives no word. A clear, or a refresh of an empty frame, loads the
// off word into the output register from ST_OFF once the slot is free. Any
// other refresh walks the dot positions from 0 at one position a cycle, a lit
// dot waiting for a free output slot, and ends on the last lit dot.
// A new command is taken only once the previous run is loaded in the output
// register. Reset clears the frame to dark and empties the output register.
// ----------------------------------------------------------------------------
module led_matrix_scroll_dot_scanner_core (
  input logic       clk,
  input logic       rst_n,
  lms_in_if.sink    in_ch,
  lms_out_if.source out_ch
);

  lms_pkg::lms_cmd_t cmd;
  lms_pkg::lms_sts_t sts;

  lms_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .in_ready   (in_ch.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  lms_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_column_bits  (in_ch.column_bits),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_serial_word (out_ch.serial_word),
    .out_dot_row     (out_ch.dot_row),
    .out_dot_column  (out_ch.dot_column),
    .out_blank       (out_ch.blank),
    .out_last        (out_ch.last)
  );

endmodule

### rtl/lms_ctrl.sv
// ----------------------------------------------------------------------------
// lms_ctrl
// Command sequencer: decodes accepted commands and walks the refresh scan.
// ----------------------------------------------------------------------------
module lms_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_command,
  output logic              in_ready,
  input  lms_pkg::lms_sts_t sts,
  output lms_pkg::lms_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_OFF,
    ST_SCAN
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_command)
            lms_pkg::CMD_SHIFT: cmd.shift = 1'b1;
            lms_pkg::CMD_CLEAR: begin
              cmd.clear = 1'b1;
              state_nxt = ST_OFF;
            end
            lms_pkg::CMD_REFRESH: begin
              if (sts.frame_empty) begin
                state_nxt = ST_OFF;
              end else begin
                cmd.load_scan = 1'b1;
                state_nxt     = ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_OFF: begin
        if (sts.slot_free) begin
          cmd.emit_off = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_SCAN: begin
        // Unlit positions are skipped at one per cycle; a lit one waits for
        // the output slot.
        if (sts.cur_lit) begin
          if (sts.slot_free) begin
            cmd.emit_dot = 1'b1;
            if (sts.more_lit) begin
              cmd.step = 1'b1;
            end else begin
              state_nxt = ST_IDLE;
            end
          end
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.emit_dot, cmd.emit_off}))
    else $error("dot and off words loaded in the same cycle");

  a_scan_ends_on_lit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && state_nxt == ST_IDLE) |-> (cmd.emit_dot && !sts.more_lit))
    else $error("scan left before its final dot was sent");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_scan |-> !sts.frame_empty)
    else $error("scan started on an empty frame");

endmodule

### rtl/lms_datapath.sv
// ----------------------------------------------------------------------------
// lms_datapath
// Frame rows, scan position, remaining-dot vector and the output register.
// ----------------------------------------------------------------------------
module lms_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lms_pkg::lms_cmd_t             cmd,
  output lms_pkg::lms_sts_t             sts,
  input  logic [lms_pkg::ROWS-1:0]      in_column_bits,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [lms_pkg::WORD_W-1:0]    out_serial_word,
  output logic [lms_pkg::ROW_W-1:0]     out_dot_row,
  output logic [lms_pkg::COL_W-1:0]     out_dot_column,
  output logic                          out_blank,
  output logic                          out_last
);

  logic [lms_pkg::COLS-1:0]   rows_r [lms_pkg::ROWS];
  logic [lms_pkg::DOTS-1:0]   lit_vec;
  logic [lms_pkg::DOTS-1:0]   rem_r;
  logic [lms_pkg::POS_W-1:0]  pos_r;
  logic                       out_valid_r;
  logic [lms_pkg::WORD_W-1:0] word_r;
  logic [lms_pkg::ROW_W-1:0]  row_r;
  logic [lms_pkg::COL_W-1:0]  col_r;
  logic                       blank_r;
  logic                       last_r;
  logic [lms_pkg::ROW_W-1:0]  pos_row;
  logic [lms_pkg::COL_W-1:0]  pos_col;

  // Scan order is column-major; column n of a row is its bit (7 - n).
  always_comb begin
    for (int c = 0; c < lms_pkg::COLS; c++) begin
      for (int r = 0; r < lms_pkg::ROWS; r++) begin
        lit_vec[c * lms_pkg::ROWS + r] = rows_r[r][lms_pkg::COLS - 1 - c];
      end
    end
  end

  assign pos_row = pos_r[lms_pkg::ROW_W-1:0];
  assign pos_col = pos_r[lms_pkg::POS_W-1:lms_pkg::ROW_W];

  always_comb begin
    sts.frame_empty = (lit_vec == '0);
    sts.cur_lit     = rem_r[0];
    sts.more_lit    = |rem_r[lms_pkg::DOTS-1:1];
    sts.slot_free   = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < lms_pkg::ROWS; r++) begin
        rows_r[r] <= '0;
      end
    end else if (cmd.clear) begin
      for (int r = 0; r < lms_pkg::ROWS; r++) begin
        rows_r[r] <= '0;
      end
    end else if (cmd.shift) begin
      for (int r = 0; r < lms_pkg::ROWS; r++) begin
        rows_r[r] <= {rows_r[r][lms_pkg::COLS-2:0], in_column_bits[r]};
      end
    end
  end

  // The frame holds still during a scan, so a shifting copy of its lit
  // positions tells both the current dot and whether any follow.
  always_ff @(posedge clk) begin
    if (cmd.load_scan) begin
      rem_r <= lit_vec;
      pos_r <= '0;
    end else if (cmd.step) begin
      rem_r <= rem_r >> 1;
      pos_r <= pos_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_dot || cmd.emit_off) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_dot) begin
      word_r  <= lms_pkg::dot_word(pos_row, pos_col);
      row_r   <= pos_row;
      col_r   <= pos_col;
      blank_r <= 1'b0;
      last_r  <= !sts.more_lit;
    end else if (cmd.emit_off) begin
      word_r  <= lms_pkg::OFF_WORD;
      row_r   <= '0;
      col_r   <= '0;
      blank_r <= 1'b1;
      last_r  <= 1'b1;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_serial_word = word_r;
  assign out_dot_row     = row_r;
  assign out_dot_column  = col_r;
  assign out_blank       = blank_r;
  assign out_last        = last_r;

  a_emit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_dot || cmd.emit_off) |-> sts.slot_free)
    else $error("output register overwritten before its transfer");

  a_blank_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && blank_r) |-> (last_r && word_r == lms_pkg::OFF_WORD))
    else $error("off word without last flag");

  a_no_pos_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (pos_r != '1))
    else $error("scan position wrapped");

endmodule
